[hdl/movem_pkg.sv]
// package: word layouts, sequencer states and timing table for the movem sequencer
package movem_pkg;

  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 88;
  localparam int unsigned REG_COUNT  = 16;

  // input word, first field in the highest bits
  typedef struct packed {
    logic [31:0] base_value;
    logic [31:0] effective_address;
    logic [15:0] register_mask;
    logic [15:0] opcode;
  } in_word_t;

  // result word, first field in the highest bits
  typedef struct packed {
    logic [3:0]  pad;
    logic [7:0]  cycles;
    logic [31:0] new_base;
    logic [2:0]  base_reg;
    logic        base_update;
    logic        use_saved_base;
    logic        word_sext;
    logic        long_size;
    logic        to_memory;
    logic [31:0] bus_address;
    logic [3:0]  reg_number;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DIFF,
    ST_FINAL
  } seq_state_t;

  localparam logic [2:0] MODE_POSTINC = 3'd3;
  localparam logic [2:0] MODE_PREDEC  = 3'd4;
  localparam logic [2:0] MODE_EXT     = 3'd7;

  localparam int unsigned OP_LONG_BIT = 6;
  localparam int unsigned OP_LOAD_BIT = 10;

  // table base cycles by mode and direction; invalid combinations give 0
  function automatic logic [7:0] base_cycles(input logic [15:0] op);
    logic [2:0] mode;
    logic [2:0] rg;
    logic       load;
    logic [7:0] c;
    mode = op[5:3];
    rg   = op[2:0];
    load = op[OP_LOAD_BIT];
    c    = 8'd0;
    case (mode)
      3'd2:    c = load ? 8'd12 : 8'd8;
      3'd3:    c = load ? 8'd12 : 8'd0;
      3'd4:    c = load ? 8'd0  : 8'd8;
      3'd5:    c = load ? 8'd16 : 8'd12;
      3'd6:    c = load ? 8'd18 : 8'd14;
      MODE_EXT: begin
        case (rg)
          3'd0:    c = load ? 8'd16 : 8'd12;
          3'd1:    c = load ? 8'd20 : 8'd16;
          3'd2:    c = load ? 8'd16 : 8'd0;
          3'd3:    c = load ? 8'd18 : 8'd0;
          default: c = 8'd0;
        endcase
      end
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

[hdl/movem_register_list_sequencer_unit.sv]
// top level: movem register list sequencer with one shared 32-bit adder
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  in_     | in  | in_tvalid/tready   | in_tdata: opcode, register_mask, ea, base
//  out_    | out | out_tvalid/tready  | out_tdata fields, out_tuser is_transfer,
//          |     |                    | out_tlast on the final word
//
// an instruction word is taken in idle, then the walk steps through the mask
// bits up to the highest set one, then ST_DIFF forms the displacement and
// ST_FINAL builds the final word; the single shared adder steps the address
// and forms new_base.
// reset (rst_n low, synchronous) returns to idle with no result pending.
// a stall on out_tready holds the walk at the next set bit; clear bits still
// advance while the output register is full.
module movem_register_list_sequencer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // opcode, register_mask, effective_address, base_value
  input  logic [movem_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // reg_number, bus_address, to_memory, long_size, word_sext, use_saved_base,
  // base_update, base_reg, new_base, cycles, zero pad
  output logic [movem_pkg::OUT_DATA_W-1:0] out_tdata,
  // is_transfer
  output logic                            out_tuser,
  output logic                            out_tlast
);
  import movem_pkg::*;

  localparam int unsigned POS_W = $clog2(REG_COUNT);

  seq_state_t state_r, state_nxt;

  in_word_t              in_w;
  logic [15:0]           op_r, op_nxt;
  logic [REG_COUNT-1:0]  mask_r, mask_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [31:0]           cur_r, cur_nxt;
  logic [31:0]           start_r, start_nxt;
  logic [31:0]           base_r, base_nxt;
  logic [7:0]            cyc_r, cyc_nxt;

  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_data_r, out_data_nxt;
  logic                  out_user_r, out_user_nxt;
  logic                  out_last_r, out_last_nxt;

  // shared adder
  logic [31:0] add_a, add_b, add_sum;
  logic        add_sub;

  logic        is_long, is_load, predec, postinc;
  logic        load_ok;
  logic [3:0]  reg_num;
  logic [31:0] step;

  assign in_w    = in_word_t'(in_tdata);
  assign is_long = op_r[OP_LONG_BIT];
  assign is_load = op_r[OP_LOAD_BIT];
  assign predec  = (op_r[5:3] == MODE_PREDEC);
  assign postinc = (op_r[5:3] == MODE_POSTINC);
  assign step    = {29'd0, is_long, ~is_long, 1'b0};
  assign load_ok = !out_valid_r || out_tready;

  // reversed register order only for predecrement stores
  assign reg_num = (!is_load && predec) ? 4'(~pos_r) : 4'(pos_r);

  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + {31'd0, add_sub};

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    mask_nxt      = mask_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    start_nxt     = start_r;
    base_nxt      = base_r;
    cyc_nxt       = cyc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    add_a         = cur_r;
    add_b         = step;
    add_sub       = predec;
    in_tready     = (state_r == ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_w.opcode;
          mask_nxt  = in_w.register_mask;
          pos_nxt   = '0;
          cur_nxt   = in_w.effective_address;
          start_nxt = in_w.effective_address;
          base_nxt  = in_w.base_value;
          cyc_nxt   = base_cycles(in_w.opcode);
          state_nxt = (in_w.register_mask == '0) ? ST_DIFF : ST_WALK;
        end
      end
      ST_WALK: begin
        if (!mask_r[0] || load_ok) begin
          if (mask_r[0]) begin
            out_valid_nxt               = 1'b1;
            out_user_nxt                = 1'b1;
            out_last_nxt                = 1'b0;
            out_data_nxt                = '0;
            out_data_nxt.reg_number     = reg_num;
            out_data_nxt.bus_address    = cur_r;
            out_data_nxt.to_memory      = !is_load;
            out_data_nxt.long_size      = is_long;
            out_data_nxt.word_sext      = is_load && !is_long;
            out_data_nxt.use_saved_base = !is_load && predec &&
                                          (reg_num == {1'b1, op_r[2:0]});
            cur_nxt                     = add_sum;
            cyc_nxt                     = cyc_r + (is_long ? 8'd8 : 8'd4);
          end
          mask_nxt = mask_r >> 1;
          pos_nxt  = pos_r + POS_W'(1);
          if ((mask_r >> 1) == '0) begin
            state_nxt = ST_DIFF;
          end
        end
      end
      ST_DIFF: begin
        // displacement = current - start, kept in the address register
        add_a     = cur_r;
        add_b     = start_r;
        add_sub   = 1'b1;
        cur_nxt   = add_sum;
        state_nxt = ST_FINAL;
      end
      ST_FINAL: begin
        add_a   = base_r;
        add_b   = cur_r;
        add_sub = 1'b0;
        if (load_ok) begin
          out_valid_nxt            = 1'b1;
          out_user_nxt             = 1'b0;
          out_last_nxt             = 1'b1;
          out_data_nxt             = '0;
          out_data_nxt.base_update = predec || postinc;
          out_data_nxt.base_reg    = op_r[2:0];
          out_data_nxt.new_base    = add_sum;
          out_data_nxt.cycles      = cyc_r;
          state_nxt                = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    mask_r     <= mask_nxt;
    pos_r      <= pos_nxt;
    cur_r      <= cur_nxt;
    start_r    <= start_nxt;
    base_r     <= base_nxt;
    cyc_r      <= cyc_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule
